// ===== hdl/mvc_pkg.sv =====
// ----------------------------------------------------------------------------
// mvc_pkg
// Shared types and codes for the meter valve controller: phase codes, request
// codes, register indexes and the structures passed between its modules.
// ----------------------------------------------------------------------------
package mvc_pkg;

  // Phase codes of the valve sequencer.
  localparam logic [3:0] PH_OFF     = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_START_X = 4'd2;
  localparam logic [3:0] PH_ON      = 4'd3;
  localparam logic [3:0] PH_ON_X    = 4'd4;
  localparam logic [3:0] PH_SREL    = 4'd5;
  localparam logic [3:0] PH_SREL_X  = 4'd6;
  localparam logic [3:0] PH_DELAY   = 4'd7;
  localparam logic [3:0] PH_DELAY_X = 4'd8;
  localparam logic [3:0] PH_RELEASE = 4'd9;

  // Request codes carried by an input request.
  localparam logic [2:0] REQ_STEP     = 3'd0;
  localparam logic [2:0] REQ_START    = 3'd1;
  localparam logic [2:0] REQ_START_X  = 3'd2;
  localparam logic [2:0] REQ_RELEASE  = 3'd3;
  localparam logic [2:0] REQ_TOP_REED = 3'd4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_VALVE_ON_TIME_MS     = 8'd0;
  localparam logic [7:0] CFG_REED_NORMALLY_CLOSED = 8'd1;

  // The on-time is kept in 10 ms ticks. floor(ms / 10) is taken as
  // (ms * 52429) >> 19, which is exact for every 16-bit value.
  localparam int          TICK_W       = 13;
  localparam logic [16:0] DIV10_MUL    = 17'd52429;
  localparam int          DIV10_SHIFT  = 19;
  localparam logic [15:0] ON_MS_RESET  = 16'd1000;
  localparam logic [TICK_W-1:0] ON_TICKS_RESET = TICK_W'(ON_MS_RESET / 10);

  typedef struct packed {
    logic [TICK_W-1:0] on_ticks;
    logic              reed_nc;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] now_10ms;
    logic        reed_level;
    logic        stop_short_release;
    logic        inhibit_reed_start;
  } req_t;

  typedef struct packed {
    logic       valve_drive;
    logic [3:0] valve_phase;
    logic       dump_done;
  } result_t;

endpackage

// ===== hdl/mvc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mvc_cfg_regs
// Configuration registers. The on-time is converted from milliseconds to
// 10 ms ticks as it is written, so the sequencer only sees ticks.
// ----------------------------------------------------------------------------
module mvc_cfg_regs
  import mvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  logic [TICK_W-1:0] on_ticks_r, on_ticks_nxt;
  logic              reed_nc_r, reed_nc_nxt;
  logic [32:0]       div_prod;

  assign div_prod = 33'(cfg_data) * 33'(DIV10_MUL);

  always_comb begin
    on_ticks_nxt = on_ticks_r;
    reed_nc_nxt  = reed_nc_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_VALVE_ON_TIME_MS) begin
        on_ticks_nxt = div_prod[DIV10_SHIFT +: TICK_W];
      end
      if (cfg_index == CFG_REED_NORMALLY_CLOSED) begin
        reed_nc_nxt = cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ticks_r <= ON_TICKS_RESET;
      reed_nc_r  <= 1'b0;
    end else begin
      on_ticks_r <= on_ticks_nxt;
      reed_nc_r  <= reed_nc_nxt;
    end
  end

  assign cfg.on_ticks = on_ticks_r;
  assign cfg.reed_nc  = reed_nc_r;

endmodule

// ===== hdl/mvc_seq.sv =====
// ----------------------------------------------------------------------------
// mvc_seq
// Valve sequencer: holds phase, phase start time and drive, and computes the
// result of one request in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module mvc_seq
  import mvc_pkg::*;
#(
  parameter int RETRY_DELAY_TICKS = 20
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  req_t    req,
  input  cfg_t    cfg,
  output result_t res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] start_r, start_nxt;
  logic        drive_r, drive_nxt;
  logic        done;
  logic [3:0]  phase_eff;
  logic        run_pass;
  logic [15:0] on_diff, delay_diff;
  logic        on_passed, delay_passed, settled;

  // Wrap-safe deadline compares: passed when now - deadline is below 0x8000.
  assign on_diff      = req.now_10ms - (start_r + 16'(cfg.on_ticks));
  assign delay_diff   = req.now_10ms - (start_r + 16'(RETRY_DELAY_TICKS));
  assign on_passed    = ~on_diff[15];
  assign delay_passed = ~delay_diff[15];
  assign settled      = cfg.reed_nc ? ~req.reed_level : req.reed_level;

  always_comb begin
    phase_eff = phase_r;
    run_pass  = 1'b1;
    unique case (req.req_type)
      REQ_START:    phase_eff = PH_START;
      REQ_START_X:  phase_eff = PH_START_X;
      REQ_RELEASE:  phase_eff = PH_RELEASE;
      REQ_TOP_REED: run_pass = 1'b0;
      default:      phase_eff = phase_r;
    endcase
  end

  always_comb begin
    phase_nxt = phase_eff;
    start_nxt = start_r;
    drive_nxt = drive_r;
    done      = 1'b0;
    if (!run_pass) begin
      if (!req.inhibit_reed_start) begin
        drive_nxt = 1'b1;
        start_nxt = req.now_10ms;
        phase_nxt = PH_ON;
      end else begin
        phase_nxt = phase_r;
      end
    end else begin
      unique case (phase_eff)
        PH_ON, PH_ON_X: begin
          if (on_passed) begin
            if (settled || phase_eff == PH_ON_X) begin
              drive_nxt = 1'b0;
              phase_nxt = PH_OFF;
              done      = 1'b1;
            end else begin
              if (!cfg.reed_nc) begin
                drive_nxt = 1'b0;
              end
              phase_nxt = PH_SREL;
            end
          end
        end
        PH_START, PH_START_X: begin
          drive_nxt = 1'b1;
          start_nxt = req.now_10ms;
          phase_nxt = (phase_eff == PH_START_X) ? PH_ON_X : PH_ON;
        end
        PH_RELEASE: begin
          drive_nxt = 1'b0;
          phase_nxt = PH_OFF;
        end
        PH_SREL, PH_SREL_X: begin
          drive_nxt = 1'b0;
          if (req.stop_short_release) begin
            phase_nxt = PH_OFF;
          end else begin
            start_nxt = req.now_10ms;
            phase_nxt = (phase_eff == PH_SREL_X) ? PH_DELAY_X : PH_DELAY;
          end
        end
        PH_DELAY, PH_DELAY_X: begin
          if (delay_passed) begin
            phase_nxt = (phase_eff == PH_DELAY_X) ? PH_START_X : PH_START;
          end
        end
        default: phase_nxt = phase_eff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OFF;
      start_r <= 16'd0;
      drive_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign res.valve_drive = drive_nxt;
  assign res.valve_phase = phase_nxt;
  assign res.dump_done   = done;

endmodule

// ===== hdl/meter_valve_controller.sv =====
// ----------------------------------------------------------------------------
// meter_valve_controller
// Dump valve sequencer for a float meter, one result per request.
// ----------------------------------------------------------------------------
// How the block is used:
// Requests arrive on the in_ channel (valid/ready). Each carries a request
// code, the 10 ms tick stamp, the raw reed level and two gating flags. Every
// accepted request yields exactly one result on the out_ channel with the
// valve drive, the phase after the update and the dump-done flag.
// Configuration writes come on the cfg_ channel; cfg_ready is always high and
// index 0 sets the on-time in ms, index 1 the reed contact type. Other indexes
// are accepted and ignored. Writes are meant for times when the block is idle.
// An accepted request is held in the input register, is processed as it
// moves into the result register, and its result is then valid on out_.
// Throughput: one request per clock while out_ready is high. The sequencer
// state is updated in the same cycle the result register is loaded, so the
// next request sees it.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only while both are full and out_ready is low.
// Reset (rst_n low, synchronous) clears both valid flags, sets the phase to
// off with the valve de-energised, start time zero, on-time 1000 ms and a
// normally open reed.
// ----------------------------------------------------------------------------
module meter_valve_controller
  import mvc_pkg::*;
#(
  parameter int RETRY_DELAY_TICKS = 20
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_now_10ms,
  input  logic        in_reed_level,
  input  logic        in_stop_short_release,
  input  logic        in_inhibit_reed_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valve_drive,
  output logic [3:0]  out_valve_phase,
  output logic        out_dump_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  req_t    req_r;
  result_t res;
  result_t res_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;
  logic    s1_fire;
  logic    in_fire;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  mvc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register can take a new value when it is empty or being read.
  assign advance  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // Input register: the request payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.req_type           <= in_req_type;
      req_r.now_10ms           <= in_now_10ms;
      req_r.reed_level         <= in_reed_level;
      req_r.stop_short_release <= in_stop_short_release;
      req_r.inhibit_reed_start <= in_inhibit_reed_start;
    end
  end

  mvc_seq #(
    .RETRY_DELAY_TICKS (RETRY_DELAY_TICKS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_fire),
    .req     (req_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valve_drive = res_r.valve_drive;
  assign out_valve_phase = res_r.valve_phase;
  assign out_dump_done   = res_r.dump_done;

endmodule

// ===== hdl/mvc_checker.sv =====
// ----------------------------------------------------------------------------
// mvc_checker
// Port-level assertions for the meter valve controller, bound to the top.
// ----------------------------------------------------------------------------
module mvc_checker
  import mvc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_valve_drive,
  input logic [3:0] out_valve_phase,
  input logic       out_dump_done
);

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valve_drive) &&
      $stable(out_valve_phase) && $stable(out_dump_done))
    else $error("stalled result changed");

  // A completed dump always leaves the valve off and closed.
  a_done_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dump_done |-> !out_valve_drive && out_valve_phase == PH_OFF)
    else $error("dump done without valve off");

  // In the off phase the valve is never energised.
  a_off_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valve_phase == PH_OFF |-> !out_valve_drive)
    else $error("valve driven while off");

  // The release phase always resolves to off within its own pass, so it is
  // never reported, and no code beyond it exists. A start phase can be
  // reported when the retry delay runs out.
  a_no_transient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_valve_phase != PH_RELEASE && out_valve_phase <= PH_RELEASE)
    else $error("transient or unknown phase reported");

endmodule

bind meter_valve_controller mvc_checker u_mvc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_valve_drive (out_valve_drive),
  .out_valve_phase (out_valve_phase),
  .out_dump_done   (out_dump_done)
);
